### hdl/vector_stream_line_projector_macros.svh
// Assertion helpers shared by the projector RTL.
`ifndef VECTOR_STREAM_LINE_PROJECTOR_MACROS_SVH
`define VECTOR_STREAM_LINE_PROJECTOR_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define VSLP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define VSLP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vslp_pkg.sv
`default_nettype none

package vslp_pkg;

    localparam int WORD_W  = 16;
    localparam int COORD_W = 20;
    localparam int SCALE_W = 32;
    localparam int COLOR_W = 16;
    localparam int PIX_W   = 16;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 135;
    localparam int NEAR_MARGIN   = 50;

    localparam logic signed [WORD_W-1:0] MARK_END  = 16'sh7FFF;
    localparam logic signed [WORD_W-1:0] MARK_BBOX = 16'sh7FFE;

    localparam logic signed [PIX_W-1:0] PREV_RESET = PIX_W'(-9999);
    localparam logic signed [PIX_W-1:0] NEAR_LO    = PIX_W'(-NEAR_MARGIN);
    localparam logic signed [PIX_W-1:0] NEAR_X_HI  = PIX_W'(SCREEN_WIDTH + NEAR_MARGIN);
    localparam logic signed [PIX_W-1:0] NEAR_Y_HI  = PIX_W'(SCREEN_HEIGHT + NEAR_MARGIN);

    // word*16 and the 20 bit bounds differ by up to 2^20
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int PROD_SHIFT = 24;
    localparam int PIXW_W     = PROD_W - PROD_SHIFT;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LAT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LAT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LON_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_LON_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COLOR   = 3'd6;

    typedef enum logic [1:0] {
        CMD_PAIR  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_DONE  = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                 kind;
        logic signed [WORD_W-1:0]  lat;
        logic signed [WORD_W-1:0]  lon;
    } cmd_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] lat_min;
        logic signed [COORD_W-1:0] lat_max;
        logic signed [COORD_W-1:0] lon_min;
        logic signed [COORD_W-1:0] lon_max;
        logic [SCALE_W-1:0]        x_scale;
        logic [SCALE_W-1:0]        y_scale;
        logic [COLOR_W-1:0]        line_color;
    } cfg_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] x_start;
        logic signed [PIX_W-1:0] y_start;
        logic signed [PIX_W-1:0] x_end;
        logic signed [PIX_W-1:0] y_end;
        logic [COLOR_W-1:0]      color;
        logic                    map_done;
    } line_t;

endpackage

`default_nettype wire

### hdl/vslp_if.sv
`default_nettype none

interface vslp_word_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vslp_pkg::WORD_W-1:0]   word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

interface vslp_line_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [vslp_pkg::PIX_W-1:0]    x_start;
    logic signed [vslp_pkg::PIX_W-1:0]    y_start;
    logic signed [vslp_pkg::PIX_W-1:0]    x_end;
    logic signed [vslp_pkg::PIX_W-1:0]    y_end;
    logic [vslp_pkg::COLOR_W-1:0]         color;
    logic                                 map_done;

    modport source (output valid, output x_start, output y_start, output x_end,
                    output y_end, output color, output map_done, input ready);
    modport sink   (input valid, input x_start, input y_start, input x_end,
                    input y_end, input color, input map_done, output ready);
endinterface

`default_nettype wire

### hdl/vslp_front.sv
`default_nettype none

module vslp_front
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               word_valid,
    input  wire logic signed [vslp_pkg::WORD_W-1:0] word,
    input  wire logic                               space,
    input  wire vslp_pkg::cfg_t                     cfg,
    output logic                                    push,
    output vslp_pkg::cmd_t                          cmd
);

    localparam logic [2:0] PH_LAT       = 3'd0;
    localparam logic [2:0] PH_LON       = 3'd1;
    localparam logic [2:0] PH_BBOX      = 3'd2;
    localparam logic [2:0] PH_SKIP      = 3'd3;
    localparam logic [2:0] PH_AFTER_END = 3'd4;

    logic [2:0]                        phase_reg, phase_next;
    logic [1:0]                        bbox_cnt_reg, bbox_cnt_next;
    logic signed [vslp_pkg::WORD_W-1:0] box_lo_lat_reg, box_lo_lat_next;
    logic signed [vslp_pkg::WORD_W-1:0] box_hi_lat_reg, box_hi_lat_next;
    logic signed [vslp_pkg::WORD_W-1:0] box_lo_lon_reg, box_lo_lon_next;
    logic signed [vslp_pkg::WORD_W-1:0] held_lat_reg, held_lat_next;

    logic accept;
    logic lat_path;
    logic outside;

    assign accept = word_valid && space;

    // last bbox word is the max longitude, taken straight from the input
    always_comb
    begin
        outside = ($signed({box_hi_lat_reg, 4'b0000}) < cfg.lat_min)
               || ($signed({box_lo_lat_reg, 4'b0000}) > cfg.lat_max)
               || ($signed({word, 4'b0000}) < cfg.lon_min)
               || ($signed({box_lo_lon_reg, 4'b0000}) > cfg.lon_max);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bbox_cnt_next   = bbox_cnt_reg;
        box_lo_lat_next = box_lo_lat_reg;
        box_hi_lat_next = box_hi_lat_reg;
        box_lo_lon_next = box_lo_lon_reg;
        held_lat_next   = held_lat_reg;
        push            = 1'b0;
        cmd.kind        = vslp_pkg::CMD_PAIR;
        cmd.lat         = held_lat_reg;
        cmd.lon         = word;
        lat_path        = 1'b0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_LON:
                begin
                    push       = 1'b1;
                    phase_next = PH_LAT;
                end
                PH_BBOX:
                begin
                    if (bbox_cnt_reg == 2'd3)
                    begin
                        push          = 1'b1;
                        cmd.kind      = vslp_pkg::CMD_CLEAR;
                        bbox_cnt_next = 2'd0;
                        phase_next    = outside ? PH_SKIP : PH_LAT;
                    end
                    else
                    begin
                        bbox_cnt_next = bbox_cnt_reg + 2'd1;
                        if (bbox_cnt_reg == 2'd0)
                        begin
                            box_lo_lat_next = word;
                        end
                        else if (bbox_cnt_reg == 2'd1)
                        begin
                            box_hi_lat_next = word;
                        end
                        else
                        begin
                            box_lo_lon_next = word;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (word == vslp_pkg::MARK_END)
                    begin
                        phase_next = PH_LAT;
                    end
                end
                PH_AFTER_END:
                begin
                    if (word == vslp_pkg::MARK_END)
                    begin
                        push          = 1'b1;
                        cmd.kind      = vslp_pkg::CMD_DONE;
                        bbox_cnt_next = 2'd0;
                        phase_next    = PH_LAT;
                    end
                    else
                    begin
                        lat_path = 1'b1;
                    end
                end
                default:
                begin
                    lat_path = 1'b1;
                end
            endcase

            if (lat_path)
            begin
                priority if (word == vslp_pkg::MARK_END)
                begin
                    push       = 1'b1;
                    cmd.kind   = vslp_pkg::CMD_CLEAR;
                    phase_next = PH_AFTER_END;
                end
                else if (word == vslp_pkg::MARK_BBOX)
                begin
                    bbox_cnt_next = 2'd0;
                    phase_next    = PH_BBOX;
                end
                else
                begin
                    held_lat_next = word;
                    phase_next    = PH_LON;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_LAT;
            bbox_cnt_reg <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            bbox_cnt_reg <= bbox_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        box_lo_lat_reg <= box_lo_lat_next;
        box_hi_lat_reg <= box_hi_lat_next;
        box_lo_lon_reg <= box_lo_lon_next;
        held_lat_reg   <= held_lat_next;
    end

endmodule

`default_nettype wire

### hdl/vslp_queue.sv
`default_nettype none
`include "vector_stream_line_projector_macros.svh"

module vslp_queue
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire vslp_pkg::cmd_t  push_cmd,
    output logic                 space,
    output logic                 head_valid,
    output vslp_pkg::cmd_t       head_cmd,
    input  wire logic            pop
);

    vslp_pkg::cmd_t entry_reg [vslp_pkg::QUEUE_DEPTH];

    logic [vslp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vslp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [vslp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    assign space      = count_reg != vslp_pkg::QUEUE_CNT_W'(vslp_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // pointers wrap on their own, depth is a power of two
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + vslp_pkg::QUEUE_CNT_W'(push)
                    - vslp_pkg::QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `VSLP_ASSERT_NOW(a_queue_no_overflow, push && !pop, space, "push into full queue")
    `VSLP_ASSERT_NOW(a_queue_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

### hdl/vslp_back.sv
`default_nettype none
`include "vector_stream_line_projector_macros.svh"

module vslp_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            head_valid,
    input  wire vslp_pkg::cmd_t  head_cmd,
    output logic                 pop,
    input  wire vslp_pkg::cfg_t  cfg,
    output logic                 line_valid,
    input  wire logic            line_ready,
    output vslp_pkg::line_t      line
);

    function automatic logic signed [vslp_pkg::PIX_W-1:0] saturate(
        input logic [vslp_pkg::PIXW_W-1:0] p,
        input logic                        neg
    );
        logic signed [vslp_pkg::PIX_W-1:0] r;
        if (neg)
        begin
            if (p > vslp_pkg::PIXW_W'(32768))
                r = 16'sh8000;
            else
                r = $signed(~p[vslp_pkg::PIX_W-1:0] + 16'd1);
        end
        else
        begin
            if (p > vslp_pkg::PIXW_W'(32767))
                r = 16'sh7FFF;
            else
                r = $signed(p[vslp_pkg::PIX_W-1:0]);
        end
        return r;
    endfunction

    function automatic logic near_screen(
        input logic signed [vslp_pkg::PIX_W-1:0] x,
        input logic signed [vslp_pkg::PIX_W-1:0] y
    );
        return (x > vslp_pkg::NEAR_LO) && (x < vslp_pkg::NEAR_X_HI)
            && (y > vslp_pkg::NEAR_LO) && (y < vslp_pkg::NEAR_Y_HI);
    endfunction

    logic advance;

    // stage 1: offsets as sign and magnitude
    logic                             s1_valid_reg;
    vslp_pkg::cmd_kind_t              s1_kind_reg;
    logic                             s1_neg_x_reg, s1_neg_y_reg;
    logic [vslp_pkg::DIFF_W-1:0]      s1_mag_x_reg, s1_mag_y_reg;
    // stage 2: products
    logic                             s2_valid_reg;
    vslp_pkg::cmd_kind_t              s2_kind_reg;
    logic                             s2_neg_x_reg, s2_neg_y_reg;
    logic [vslp_pkg::PROD_W-1:0]      s2_prod_x_reg, s2_prod_y_reg;
    // stage 3: pixel
    logic                             s3_valid_reg;
    vslp_pkg::cmd_kind_t              s3_kind_reg;
    logic signed [vslp_pkg::PIX_W-1:0] s3_x_reg, s3_y_reg;

    logic signed [vslp_pkg::PIX_W-1:0] prev_x_reg, prev_x_next;
    logic signed [vslp_pkg::PIX_W-1:0] prev_y_reg, prev_y_next;
    logic                              prev_near_reg, prev_near_next;
    logic                              seg_reg, seg_next;
    logic                              out_valid_reg, out_valid_next;
    vslp_pkg::line_t                   line_reg, line_next;

    logic [vslp_pkg::DIFF_W-1:0] lon16, lat16, lon_min21, lat_max21;
    logic [vslp_pkg::DIFF_W-1:0] dx_pos, dx_neg, dy_pos, dy_neg;
    logic                        near_cur;
    logic                        moved;

    assign advance = !out_valid_reg || line_ready;
    assign pop     = advance && head_valid;

    always_comb
    begin
        lon16     = {head_cmd.lon[vslp_pkg::WORD_W-1], head_cmd.lon, 4'b0000};
        lat16     = {head_cmd.lat[vslp_pkg::WORD_W-1], head_cmd.lat, 4'b0000};
        lon_min21 = {cfg.lon_min[vslp_pkg::COORD_W-1], cfg.lon_min};
        lat_max21 = {cfg.lat_max[vslp_pkg::COORD_W-1], cfg.lat_max};
        dx_pos    = lon16 - lon_min21;
        dx_neg    = lon_min21 - lon16;
        dy_pos    = lat_max21 - lat16;
        dy_neg    = lat16 - lat_max21;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_kind_reg   <= head_cmd.kind;
            s1_neg_x_reg  <= dx_pos[vslp_pkg::DIFF_W-1];
            s1_neg_y_reg  <= dy_pos[vslp_pkg::DIFF_W-1];
            s1_mag_x_reg  <= dx_pos[vslp_pkg::DIFF_W-1] ? dx_neg : dx_pos;
            s1_mag_y_reg  <= dy_pos[vslp_pkg::DIFF_W-1] ? dy_neg : dy_pos;

            s2_kind_reg   <= s1_kind_reg;
            s2_neg_x_reg  <= s1_neg_x_reg;
            s2_neg_y_reg  <= s1_neg_y_reg;
            s2_prod_x_reg <= s1_mag_x_reg * cfg.x_scale;
            s2_prod_y_reg <= s1_mag_y_reg * cfg.y_scale;

            s3_kind_reg   <= s2_kind_reg;
            s3_x_reg      <= saturate(s2_prod_x_reg[vslp_pkg::PROD_W-1:vslp_pkg::PROD_SHIFT],
                                      s2_neg_x_reg);
            s3_y_reg      <= saturate(s2_prod_y_reg[vslp_pkg::PROD_W-1:vslp_pkg::PROD_SHIFT],
                                      s2_neg_y_reg);
        end
    end

    // stage 4: compare with the previous pixel and build the beat
    always_comb
    begin
        near_cur       = near_screen(s3_x_reg, s3_y_reg);
        moved          = (s3_x_reg != prev_x_reg) || (s3_y_reg != prev_y_reg);
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_near_next = prev_near_reg;
        seg_next       = seg_reg;
        out_valid_next = out_valid_reg;
        line_next      = line_reg;

        if (advance)
        begin
            out_valid_next     = 1'b0;
            line_next.x_start  = prev_x_reg;
            line_next.y_start  = prev_y_reg;
            line_next.x_end    = s3_x_reg;
            line_next.y_end    = s3_y_reg;
            line_next.color    = cfg.line_color;
            line_next.map_done = 1'b0;
            if (s3_valid_reg)
            begin
                unique case (s3_kind_reg)
                    vslp_pkg::CMD_PAIR:
                    begin
                        out_valid_next = seg_reg && moved && (near_cur || prev_near_reg);
                        prev_x_next    = s3_x_reg;
                        prev_y_next    = s3_y_reg;
                        prev_near_next = near_cur;
                        seg_next       = 1'b1;
                    end
                    vslp_pkg::CMD_CLEAR:
                    begin
                        seg_next = 1'b0;
                    end
                    vslp_pkg::CMD_DONE:
                    begin
                        out_valid_next = 1'b1;
                        line_next      = '0;
                        line_next.map_done = 1'b1;
                        prev_x_next    = vslp_pkg::PREV_RESET;
                        prev_y_next    = vslp_pkg::PREV_RESET;
                        prev_near_next = 1'b0;
                        seg_next       = 1'b0;
                    end
                    default:
                    begin
                        seg_next = seg_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg    <= vslp_pkg::PREV_RESET;
            prev_y_reg    <= vslp_pkg::PREV_RESET;
            prev_near_reg <= 1'b0;
            seg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_near_reg <= prev_near_next;
            seg_reg       <= seg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
    end

    assign line_valid = out_valid_reg;
    assign line       = line_reg;

    `VSLP_ASSERT_NOW(a_line_moved, out_valid_reg && !line_reg.map_done,
        (line_reg.x_start != line_reg.x_end) || (line_reg.y_start != line_reg.y_end),
        "line beat with identical ends")
    `VSLP_ASSERT_NEXT(a_done_restarts,
        advance && s3_valid_reg && (s3_kind_reg == vslp_pkg::CMD_DONE),
        !seg_reg && out_valid_reg && line_reg.map_done && (prev_x_reg == vslp_pkg::PREV_RESET),
        "end of map did not restart the line state")

endmodule

`default_nettype wire

### hdl/vector_stream_line_projector.sv
// Throughput: one map word per cycle, sustained; a stalled line channel backs up
// through a 4-entry command queue before the word channel drops ready.
// Path: a line or done beat shows on line_stream after the edge that accepted the
// closing word, through the queue, offset, multiply, saturate and compare stages.
// Reset (rst_n, async low): parser to expect latitude, previous pixel -9999,
// queue and pipeline empty, configuration registers to their defaults.
`default_nettype none

module vector_stream_line_projector
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    vslp_word_if.sink                                 map_stream,
    vslp_line_if.source                               line_stream,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [vslp_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [vslp_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic      [vslp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                      pready
);

    vslp_pkg::cfg_t  cfg_reg;
    vslp_pkg::cfg_t  cfg_next;
    vslp_pkg::cmd_t  push_cmd;
    vslp_pkg::cmd_t  head_cmd;
    vslp_pkg::line_t line;

    logic                             push;
    logic                             space;
    logic                             head_valid;
    logic                             pop;
    logic                             wr_en;
    logic [vslp_pkg::CFG_IDX_W-1:0]   reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[vslp_pkg::CFG_ADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                vslp_pkg::REG_VIEW_LAT_MIN: cfg_next.lat_min = pwdata[vslp_pkg::COORD_W-1:0];
                vslp_pkg::REG_VIEW_LAT_MAX: cfg_next.lat_max = pwdata[vslp_pkg::COORD_W-1:0];
                vslp_pkg::REG_VIEW_LON_MIN: cfg_next.lon_min = pwdata[vslp_pkg::COORD_W-1:0];
                vslp_pkg::REG_VIEW_LON_MAX: cfg_next.lon_max = pwdata[vslp_pkg::COORD_W-1:0];
                vslp_pkg::REG_X_SCALE:      cfg_next.x_scale = pwdata;
                vslp_pkg::REG_Y_SCALE:      cfg_next.y_scale = pwdata;
                vslp_pkg::REG_LINE_COLOR:
                    cfg_next.line_color = pwdata[vslp_pkg::COLOR_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            vslp_pkg::REG_VIEW_LAT_MIN:
                prdata = vslp_pkg::CFG_DATA_W'(cfg_reg.lat_min);
            vslp_pkg::REG_VIEW_LAT_MAX:
                prdata = vslp_pkg::CFG_DATA_W'(cfg_reg.lat_max);
            vslp_pkg::REG_VIEW_LON_MIN:
                prdata = vslp_pkg::CFG_DATA_W'(cfg_reg.lon_min);
            vslp_pkg::REG_VIEW_LON_MAX:
                prdata = vslp_pkg::CFG_DATA_W'(cfg_reg.lon_max);
            vslp_pkg::REG_X_SCALE:
                prdata = cfg_reg.x_scale;
            vslp_pkg::REG_Y_SCALE:
                prdata = cfg_reg.y_scale;
            vslp_pkg::REG_LINE_COLOR:
                prdata = {{(vslp_pkg::CFG_DATA_W - vslp_pkg::COLOR_W){1'b0}},
                          cfg_reg.line_color};
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lat_min    <= 20'sh80000;
            cfg_reg.lat_max    <= 20'sh7FFFF;
            cfg_reg.lon_min    <= 20'sh80000;
            cfg_reg.lon_max    <= 20'sh7FFFF;
            cfg_reg.x_scale    <= 32'h0010_0000;
            cfg_reg.y_scale    <= 32'h0010_0000;
            cfg_reg.line_color <= 16'hFFFF;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign map_stream.ready = space;

    vslp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (map_stream.valid),
        .word       (map_stream.word),
        .space      (space),
        .cfg        (cfg_reg),
        .push       (push),
        .cmd        (push_cmd)
    );

    vslp_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .space      (space),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    vslp_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .cfg        (cfg_reg),
        .line_valid (line_stream.valid),
        .line_ready (line_stream.ready),
        .line       (line)
    );

    assign line_stream.x_start  = line.x_start;
    assign line_stream.y_start  = line.y_start;
    assign line_stream.x_end    = line.x_end;
    assign line_stream.y_end    = line.y_end;
    assign line_stream.color    = line.color;
    assign line_stream.map_done = line.map_done;

endmodule

`default_nettype wire
